FILE: rtl/axr_pkg.sv
package axr_pkg;

	typedef struct packed {
		logic       mode;
		logic [4:0] num_bytes;
	} in_t;

	typedef struct packed {
		logic [7:0] random_byte;
		logic [1:0] status;
		logic       last_of_run;
	} out_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SEED_REJ = 2'd1;
	localparam logic [1:0] ST_INVALID  = 2'd2;
	localparam logic [1:0] ST_REPEAT   = 2'd3;

	localparam logic [2:0] CFG_KEY_HI = 3'd0;
	localparam logic [2:0] CFG_KEY_LO = 3'd1;
	localparam logic [2:0] CFG_V_HI   = 3'd2;
	localparam logic [2:0] CFG_V_LO   = 3'd3;
	localparam logic [2:0] CFG_DT_HI  = 3'd4;
	localparam logic [2:0] CFG_DT_LO  = 3'd5;

	localparam logic       MODE_SEED = 1'b0;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xt(input logic [7:0] x);
		xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

FILE: rtl/axr_aes.sv
module axr_aes (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] key,
	input  logic [127:0] din,
	output logic         done,
	output logic [127:0] dout
);
	import axr_pkg::*;

	typedef enum logic [1:0] {A_IDLE, A_KEY, A_SUB, A_MIX} aes_st_t;

	aes_st_t     state_q;
	logic [3:0]  cnt_q;
	logic [3:0]  round_q;
	logic [7:0]  rc_q;
	logic [7:0]  s_q  [16];
	logic [7:0]  rk_q [16];
	logic [7:0]  t_q  [16];
	logic [7:0]  kw_q [4];
	logic [7:0]  rk_new [16];
	logic [7:0]  mix [16];
	logic [7:0]  sb_in;
	logic [7:0]  sb_out;
	logic [3:0]  sub_idx;
	logic [3:0]  key_idx;
	logic [7:0]  a0, a1, a2, a3;

	assign sub_idx = {cnt_q[3:2] + cnt_q[1:0], cnt_q[1:0]};
	assign key_idx = {2'b11, cnt_q[1:0] + 2'd1};
	assign sb_in   = (state_q == A_KEY) ? rk_q[key_idx] : s_q[sub_idx];
	assign sb_out  = SBOX[sb_in];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			rk_new[k] = rk_q[k] ^ kw_q[k] ^ ((k == 0) ? rc_q : 8'h00);
		end
		for (int k = 4; k < 16; k++) begin
			rk_new[k] = rk_q[k] ^ rk_new[k-4];
		end
	end

	always_comb begin
		a0 = '0; a1 = '0; a2 = '0; a3 = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = t_q[c*4];
			a1 = t_q[c*4+1];
			a2 = t_q[c*4+2];
			a3 = t_q[c*4+3];
			if (round_q == 4'd10) begin
				mix[c*4]   = a0;
				mix[c*4+1] = a1;
				mix[c*4+2] = a2;
				mix[c*4+3] = a3;
			end else begin
				mix[c*4]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
				mix[c*4+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
				mix[c*4+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
				mix[c*4+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 16; j++) begin
			dout[127-8*j -: 8] = s_q[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			cnt_q   <= '0;
			round_q <= '0;
			rc_q    <= 8'h01;
			done    <= 1'b0;
		end else begin
			done <= (state_q == A_MIX) && (round_q == 4'd10);
			unique case (state_q)
				A_IDLE: begin
					if (start) begin
						state_q <= A_KEY;
						cnt_q   <= '0;
						round_q <= 4'd1;
						rc_q    <= 8'h01;
					end
				end
				A_KEY: begin
					if (cnt_q == 4'd3) begin
						state_q <= A_SUB;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				A_SUB: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= A_MIX;
					end
				end
				A_MIX: begin
					cnt_q   <= '0;
					rc_q    <= xt(rc_q);
					round_q <= round_q + 4'd1;
					if (round_q == 4'd10) begin
						state_q <= A_IDLE;
					end else begin
						state_q <= A_KEY;
					end
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			A_IDLE: begin
				if (start) begin
					for (int j = 0; j < 16; j++) begin
						s_q[j]  <= din[127-8*j -: 8] ^ key[127-8*j -: 8];
						rk_q[j] <= key[127-8*j -: 8];
					end
				end
			end
			A_KEY: begin
				kw_q[cnt_q[1:0]] <= sb_out;
			end
			A_SUB: begin
				for (int j = 0; j < 15; j++) begin
					t_q[j] <= t_q[j+1];
				end
				t_q[15] <= sb_out;
			end
			A_MIX: begin
				for (int j = 0; j < 16; j++) begin
					s_q[j]  <= mix[j] ^ rk_new[j];
					rk_q[j] <= rk_new[j];
				end
			end
			default: ;
		endcase
	end

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != A_IDLE |-> (round_q >= 4'd1 && round_q <= 4'd10))
		else $error("round out of range");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == A_IDLE) else $error("done while busy");

endmodule

FILE: rtl/aes128_x931_random_generator.sv
// X9.31 random byte generator over AES-128. A seed beat (mode 0) latches key,
// V and DT from the configuration registers, unless V equals the key and the
// seed is rejected; its single result is loaded into the output register from
// the emit state once that register can take it, and a draw while unseeded
// answers the same way. A draw of n bytes collects them from the current
// block, then sends n beats out, at best one per cycle. Whenever the block is
// used up a new one is made by three encryptions on a byte-serial AES core
// with one S-box; a block equal to the last one ends the draw with an error.
// Each AES round runs a key-schedule step, SubBytes/ShiftRows byte by byte
// and then MixColumns, which the last round skips. A draw spans at most two
// blocks. Results leave through an output register; the input is stalled
// until every result of the current beat has been loaded into it.
module aes128_x931_random_generator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  axr_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output axr_pkg::out_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [63:0]   cfg_data
);
	import axr_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_GATHER, S_ENC1, S_ENC2, S_ENC3, S_EMIT} st_t;

	st_t          state_q;
	logic [127:0] cfg_key_q, cfg_v_q, cfg_dt_q;
	logic [127:0] key_q, v_q, dt_q, cur_q, prev_q, iv_q;
	logic [4:0]   idx_q;
	logic         valid_q;
	logic [4:0]   n_q;
	logic [4:0]   pos_q;
	logic [3:0]   e_q;
	logic [1:0]   st_q;
	logic         zero_q;
	logic         aes_go_q;
	logic [127:0] aes_in_q;
	logic         aes_done;
	logic [127:0] aes_out;
	logic [7:0]   buf_q [16];
	logic [7:0]   cur_byte;
	logic [4:0]   n_sat;
	logic         accept;
	logic         out_take;

	axr_aes u_aes (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (aes_go_q),
		.key    (key_q),
		.din    (aes_in_q),
		.done   (aes_done),
		.dout   (aes_out)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_take  = !out_valid || !out_stall;
	assign n_sat     = (in_data.num_bytes > 5'd16) ? 5'd16 : in_data.num_bytes;
	assign cur_byte  = cur_q[127 - 8*idx_q[3:0] -: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cfg_key_q <= '0;
			cfg_v_q   <= '0;
			cfg_dt_q  <= '0;
			key_q     <= '0;
			v_q       <= '0;
			dt_q      <= '0;
			cur_q     <= '0;
			prev_q    <= '0;
			iv_q      <= '0;
			idx_q     <= 5'd16;
			valid_q   <= 1'b0;
			n_q       <= '0;
			pos_q     <= '0;
			e_q       <= '0;
			st_q      <= ST_OK;
			zero_q    <= 1'b0;
			aes_go_q  <= 1'b0;
			aes_in_q  <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_KEY_HI: cfg_key_q[127:64] <= cfg_data;
					CFG_KEY_LO: cfg_key_q[63:0]   <= cfg_data;
					CFG_V_HI:   cfg_v_q[127:64]   <= cfg_data;
					CFG_V_LO:   cfg_v_q[63:0]     <= cfg_data;
					CFG_DT_HI:  cfg_dt_q[127:64]  <= cfg_data;
					CFG_DT_LO:  cfg_dt_q[63:0]    <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_EMIT && out_take) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					aes_go_q <= 1'b0;
					if (accept) begin
						e_q    <= 4'd15;
						zero_q <= 1'b1;
						if (in_data.mode == MODE_SEED) begin
							state_q <= S_EMIT;
							if (cfg_v_q == cfg_key_q) begin
								valid_q <= 1'b0;
								st_q    <= ST_SEED_REJ;
							end else begin
								st_q    <= ST_OK;
								v_q     <= cfg_v_q;
								key_q   <= cfg_key_q;
								dt_q    <= cfg_dt_q;
								cur_q   <= '0;
								prev_q  <= '0;
								idx_q   <= 5'd16;
								valid_q <= 1'b1;
							end
						end else if (!valid_q) begin
							st_q    <= ST_INVALID;
							state_q <= S_EMIT;
						end else if (n_sat != 5'd0) begin
							n_q     <= n_sat;
							pos_q   <= '0;
							state_q <= S_GATHER;
						end
					end
				end
				S_GATHER: begin
					aes_go_q <= idx_q[4];
					if (idx_q[4]) begin
						aes_in_q <= dt_q;
						state_q  <= S_ENC1;
					end else begin
						idx_q <= idx_q + 5'd1;
						pos_q <= pos_q + 5'd1;
						if (pos_q + 5'd1 == n_q) begin
							zero_q  <= 1'b0;
							st_q    <= ST_OK;
							e_q     <= 4'(5'd16 - n_q);
							state_q <= S_EMIT;
						end
					end
				end
				S_ENC1: begin
					aes_go_q <= aes_done;
					if (aes_done) begin
						iv_q     <= aes_out;
						aes_in_q <= aes_out ^ v_q;
						state_q  <= S_ENC2;
					end
				end
				S_ENC2: begin
					aes_go_q <= aes_done && (aes_out != prev_q);
					if (aes_done) begin
						cur_q <= aes_out;
						if (aes_out == prev_q) begin
							valid_q <= 1'b0;
							zero_q  <= 1'b1;
							st_q    <= ST_REPEAT;
							e_q     <= 4'(5'd16 - n_q);
							state_q <= S_EMIT;
						end else begin
							prev_q   <= aes_out;
							aes_in_q <= aes_out ^ iv_q;
							state_q  <= S_ENC3;
						end
					end
				end
				S_ENC3: begin
					aes_go_q <= 1'b0;
					if (aes_done) begin
						v_q     <= aes_out;
						dt_q    <= dt_q + 128'd1;
						idx_q   <= '0;
						state_q <= S_GATHER;
					end
				end
				S_EMIT: begin
					aes_go_q <= 1'b0;
					if (out_take) begin
						if (e_q == 4'd15) begin
							state_q <= S_IDLE;
						end else begin
							e_q <= e_q + 4'd1;
						end
					end
				end
				default: begin
					aes_go_q <= 1'b0;
					state_q  <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_GATHER && !idx_q[4]) begin
			for (int j = 0; j < 15; j++) begin
				buf_q[j] <= buf_q[j+1];
			end
			buf_q[15] <= cur_byte;
		end
		if (state_q == S_EMIT && out_take) begin
			out_data.random_byte <= zero_q ? 8'h00 : buf_q[e_q];
			out_data.status      <= st_q;
			out_data.last_of_run <= (e_q == 4'd15);
		end
	end

	a_go_enc: assert property (@(posedge clk) disable iff (!arst_n)
		aes_go_q |-> (state_q == S_ENC1 || state_q == S_ENC2 || state_q == S_ENC3))
		else $error("encryption started outside an encryption state");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= 5'd16) else $error("block index out of range");
	a_gather_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GATHER |-> valid_q) else $error("gathering while invalid");
	a_emit_ok_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && !zero_q) |-> st_q == ST_OK)
		else $error("error result carries data");

endmodule
